/* design/amlp_pkg.sv */
// Shared types and constants for the accelerometer magnitude low-pass block.
package amlp_pkg;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 24;

    localparam logic [CFG_INDEX_W-1:0] REG_SCALE_FACTOR = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COEF_PREV_FILT = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_COEF_PREV_MAG = 2'd2;

    localparam logic [23:0] SCALE_FACTOR_RESET = 24'd160578;
    localparam logic [15:0] COEF_PREV_FILT_RESET = 16'd29256;
    localparam logic [15:0] COEF_PREV_MAG_RESET = 16'd1756;

    localparam logic [16:0] Q15_ONE = 17'd32768;

    localparam int unsigned NUM_AXES = 3;

    typedef struct packed {
        logic signed [15:0] raw_x;
        logic signed [15:0] raw_y;
        logic signed [15:0] raw_z;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] scaled_x;
        logic signed [31:0] scaled_y;
        logic signed [31:0] scaled_z;
        logic [31:0]        magnitude;
        logic [31:0]        filtered_magnitude;
    } out_item_t;

    typedef struct packed {
        logic prod_en;
        logic acc_en;
    } filt_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MERGE,
        ST_ROOT,
        ST_MAG,
        ST_PROD,
        ST_ACC,
        ST_OUT
    } state_t;

endpackage

/* design/accel_magnitude_lowpass.sv */
// Top level: accelerometer axis scaling, vector magnitude and low-pass filter.
//
// Input channel s_valid/s_ready/s_data carries one three-axis raw sample per
// transaction. Result channel m_valid/m_ready/m_data carries the three scaled
// axes, the scaled magnitude and the filtered magnitude for that sample.
// Configuration writes arrive on cfg_valid/cfg_ready/cfg_index/cfg_data;
// cfg_ready is always high and an unknown index is ignored.
// One sample is processed at a time. From input transaction to result valid,
// the sample is registered in the axis lanes, passes the bit-serial square
// root, whose root is then handed over, and goes on to magnitude scaling,
// the two filter steps (product, then accumulate) and the output load.
// The square root takes up most of the time spent on each sample.
// The next sample is accepted as soon as the result sits in the output
// register; if the receiver stalls, the following result waits in its last
// step until the output register frees up, and no further sample is taken.
// Reset (aresetn, synchronous, active low) restores the register defaults,
// clears the filter history to zero and empties the output register.
module accel_magnitude_lowpass import amlp_pkg::*; #(
    parameter int unsigned SQRT_FRACTION_BITS = 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_item_t               s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_item_t              m_data,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int unsigned ROOT_W = 16 + SQRT_FRACTION_BITS;
    localparam int unsigned RAD_W  = 2 * ROOT_W;
    localparam int unsigned MPROD_W = ROOT_W + 24;

    state_t      state_reg, state_next;
    logic [23:0] scale_reg;
    logic [15:0] coef_a_reg;
    logic [15:0] coef_b_reg;
    logic [31:0] mag_reg;
    out_item_t   m_data_reg;
    logic        m_valid_reg;

    logic               accept;
    logic               sqrt_start;
    logic               sqrt_done;
    logic               out_load;
    filt_ctl_t          filt_ctl;
    logic signed [15:0] lane_raw [NUM_AXES];
    logic signed [31:0] lane_scaled [NUM_AXES];
    logic [31:0]        lane_square [NUM_AXES];
    logic [31:0]        sumsq;
    logic [RAD_W-1:0]   radicand;
    logic [ROOT_W-1:0]  root;
    logic [MPROD_W-1:0] mag_prod;
    logic [31:0]        filtered;

    assign accept    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg  <= SCALE_FACTOR_RESET;
            coef_a_reg <= COEF_PREV_FILT_RESET;
            coef_b_reg <= COEF_PREV_MAG_RESET;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_SCALE_FACTOR:   scale_reg  <= cfg_data;
                REG_COEF_PREV_FILT: coef_a_reg <= cfg_data[15:0];
                REG_COEF_PREV_MAG:  coef_b_reg <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign lane_raw[0] = s_data.raw_x;
    assign lane_raw[1] = s_data.raw_y;
    assign lane_raw[2] = s_data.raw_z;

    for (genvar i = 0; i < NUM_AXES; i++) begin : g_lane
        amlp_lane u_lane (
            .aclk   (aclk),
            .load   (accept),
            .raw    (lane_raw[i]),
            .scale  (scale_reg),
            .scaled (lane_scaled[i]),
            .square (lane_square[i])
        );
    end

    // Merge the lanes; the true sum stays below 2^32
    assign sumsq    = lane_square[0] + lane_square[1] + lane_square[2];
    assign radicand = RAD_W'(sumsq) << (2 * SQRT_FRACTION_BITS);

    amlp_isqrt #(
        .ROOT_W (ROOT_W)
    ) u_isqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand (radicand),
        .root     (root),
        .done     (sqrt_done)
    );

    // The shifted product is exactly 32 bits wide, so it cannot overflow
    assign mag_prod = root * scale_reg;

    always_ff @(posedge aclk) begin
        if (state_reg == ST_MAG) begin
            mag_reg <= mag_prod[MPROD_W-1 -: 32];
        end
    end

    amlp_filter u_filter (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (filt_ctl),
        .coef_a   (coef_a_reg),
        .coef_b   (coef_b_reg),
        .mag      (mag_reg),
        .filtered (filtered)
    );

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (s_valid) state_next = ST_MERGE;
            ST_MERGE: state_next = ST_ROOT;
            ST_ROOT:  if (sqrt_done) state_next = ST_MAG;
            ST_MAG:   state_next = ST_PROD;
            ST_PROD:  state_next = ST_ACC;
            ST_ACC:   state_next = ST_OUT;
            ST_OUT:   if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready          = 1'b0;
        sqrt_start       = 1'b0;
        filt_ctl.prod_en = 1'b0;
        filt_ctl.acc_en  = 1'b0;
        out_load         = 1'b0;
        case (state_reg)
            ST_IDLE:  s_ready = 1'b1;
            ST_MERGE: sqrt_start = 1'b1;
            ST_PROD:  filt_ctl.prod_en = 1'b1;
            ST_ACC:   filt_ctl.acc_en = 1'b1;
            ST_OUT:   out_load = !m_valid_reg || m_ready;
            default:  ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_data_reg.scaled_x           <= lane_scaled[0];
            m_data_reg.scaled_y           <= lane_scaled[1];
            m_data_reg.scaled_z           <= lane_scaled[2];
            m_data_reg.magnitude          <= mag_reg;
            m_data_reg.filtered_magnitude <= filtered;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef SYNTHESIS
    a_accept_to_merge: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> state_reg == ST_MERGE)
        else $error("accepted sample did not enter the merge step");

    a_root_done_in_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        sqrt_done |-> state_reg == ST_ROOT)
        else $error("square root finished outside its wait state");

    a_no_accept_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready)
        else $error("input ready while a sample is in flight");

    a_result_carries_mag: assert property (@(posedge aclk) disable iff (!aresetn)
        out_load |=> m_valid && m_data.magnitude == $past(mag_reg))
        else $error("result register lost the magnitude");
`endif

endmodule

/* design/amlp_lane.sv */
// One axis lane: scaled axis value and the square of the raw count.
module amlp_lane import amlp_pkg::*; (
    input  logic               aclk,
    input  logic               load,
    input  logic signed [15:0] raw,
    input  logic [23:0]        scale,
    output logic signed [31:0] scaled,
    output logic [31:0]        square
);

    logic signed [40:0] scale_prod;
    logic signed [31:0] raw_sq;
    logic signed [31:0] scaled_reg;
    logic [31:0]        square_reg;

    assign scale_prod = raw * $signed({1'b0, scale});
    assign raw_sq     = raw * raw;

    // Arithmetic shift right by 8 floors towards minus infinity
    always_ff @(posedge aclk) begin
        if (load) begin
            scaled_reg <= scale_prod[39:8];
            square_reg <= $unsigned(raw_sq);
        end
    end

    assign scaled = scaled_reg;
    assign square = square_reg;

endmodule

/* design/amlp_isqrt.sv */
// Bit-serial integer square root, one result bit per cycle.
module amlp_isqrt import amlp_pkg::*; #(
    parameter int unsigned ROOT_W = 24
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [2*ROOT_W-1:0] radicand,
    output logic [ROOT_W-1:0]   root,
    output logic                done
);

    localparam int unsigned CNT_W = $clog2(ROOT_W + 1);

    logic [2*ROOT_W-1:0] rad_reg, rad_next;
    logic [ROOT_W:0]     rem_reg, rem_next;
    logic [ROOT_W-1:0]   root_reg, root_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;
    logic [ROOT_W+2:0]   rem_sh;
    logic [ROOT_W+2:0]   trial;
    logic [ROOT_W+2:0]   diff;

    assign rem_sh = {rem_reg, rad_reg[2*ROOT_W-1 -: 2]};
    assign trial  = {1'b0, root_reg, 2'b01};
    assign diff   = rem_sh - trial;

    always_comb begin
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
            cnt_next  = CNT_W'(ROOT_W);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rad_next = rad_reg << 2;
            cnt_next = cnt_reg - 1'b1;
            if (rem_sh >= trial) begin
                rem_next  = diff[ROOT_W:0];
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end else begin
                rem_next  = rem_sh[ROOT_W:0];
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            if (cnt_reg == CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign root = root_reg;
    assign done = done_reg;

endmodule

/* design/amlp_filter.sv */
// First-order low-pass over the magnitude, with its history registers.
module amlp_filter import amlp_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  filt_ctl_t   ctl,
    input  logic [15:0] coef_a,
    input  logic [15:0] coef_b,
    input  logic [31:0] mag,
    output logic [31:0] filtered
);

    logic [31:0] prev_mag_reg;
    logic [31:0] prev_filt_reg;
    logic [47:0] pa_reg, pb_reg, pc_reg;
    logic [16:0] sum_ab;
    logic [15:0] coef_c;
    logic [49:0] acc;
    logic [34:0] acc_sh;
    logic [31:0] filt_next;

    assign sum_ab = {1'b0, coef_a} + {1'b0, coef_b};
    // Weights above one in total leave nothing for the current magnitude
    assign coef_c = (sum_ab > Q15_ONE) ? 16'd0 : 16'(Q15_ONE - sum_ab);

    always_ff @(posedge aclk) begin
        if (ctl.prod_en) begin
            pa_reg <= coef_a * prev_filt_reg;
            pb_reg <= coef_b * prev_mag_reg;
            pc_reg <= coef_c * mag;
        end
    end

    assign acc       = 50'(pa_reg) + 50'(pb_reg) + 50'(pc_reg);
    assign acc_sh    = acc[49:15];
    assign filt_next = (acc_sh[34:32] != 3'd0) ? 32'hFFFF_FFFF : acc_sh[31:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_mag_reg  <= '0;
            prev_filt_reg <= '0;
        end else if (ctl.acc_en) begin
            prev_mag_reg  <= mag;
            prev_filt_reg <= filt_next;
        end
    end

    assign filtered = prev_filt_reg;

endmodule
